// ===== hdl/mbd_pkg.sv =====
// Shared types, constants and helper functions of the min/max bucket decimator.
// Used by every module of the block; depends on nothing else.

package mbd_pkg;

   // Series and bucket limits
   localparam int MAX_SAMPLES = 1048576;
   localparam int MAX_BUCKETS = 4096;

   // Field widths
   localparam int IDX_W = 20;
   localparam int VAL_W = 32;
   localparam int BKT_W = 13;
   localparam int CNT_W = 21;

   // Stream widths: three fields packed from bit 0, padded to whole bytes
   localparam int TDATA_W = ((IDX_W + 2 * VAL_W + 7) / 8) * 8;

   // Configuration port
   localparam int CSR_IDX_W = 3;
   localparam logic [CSR_IDX_W-1:0] CSR_X_ORIGIN     = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_BUCKET_SCALE = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_BUCKET_COUNT = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_FIRST_INSIDE = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_AFTER_INSIDE = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_SAMPLE_COUNT = 3'd5;

   // Register reset values
   localparam logic [VAL_W-1:0] RST_BUCKET_SCALE = VAL_W'(65536);
   localparam logic [BKT_W-1:0] RST_BUCKET_COUNT = BKT_W'(1);

   // Queue between the front and back parts
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);
   localparam int QSUM_W      = QCNT_W + 1;

   // Result buffer in the back part
   localparam int RBUF_DEPTH = 4;
   localparam int RPTR_W     = $clog2(RBUF_DEPTH);
   localparam int RCNT_W     = $clog2(RBUF_DEPTH + 1);
   localparam int NUM_CAND   = 4;

   // What the back part has to do with an item
   typedef enum logic [2:0] {
      KIND_STRAY,
      KIND_PASS,
      KIND_PRE,
      KIND_INRANGE,
      KIND_POST
   } kind_type;

   typedef struct packed {
      logic [IDX_W-1:0] idx;
      logic [VAL_W-1:0] x;
      logic [VAL_W-1:0] y;
   } sample_type;

   typedef struct packed {
      sample_type       smp;
      logic [BKT_W-1:0] bucket;
      kind_type         kind;
      logic             closes;
      logic             post_put;
   } cls_item_type;

   typedef struct packed {
      sample_type smp;
      logic       decimating;
      logic       run_end;
   } rsp_type;

   typedef struct packed {
      logic [VAL_W-1:0] x_origin;
      logic [VAL_W-1:0] bucket_scale;
      logic [BKT_W-1:0] n_buckets;
      logic [CNT_W-1:0] range_first;
      logic [CNT_W-1:0] range_after;
      logic [CNT_W-1:0] sample_count;
   } csr_type;

   // Sample count saturated to the series limit
   function automatic logic [CNT_W-1:0] eff_count(csr_type c);
      logic [CNT_W-1:0] lim;
      lim = CNT_W'(MAX_SAMPLES);
      return (c.sample_count > lim) ? lim : c.sample_count;
   endfunction

   // Bucket count with zero read as one and saturated to the bucket limit
   function automatic logic [BKT_W-1:0] eff_buckets(csr_type c);
      logic [BKT_W-1:0] lim;
      lim = BKT_W'(MAX_BUCKETS);
      if (c.n_buckets == '0) begin
         return BKT_W'(1);
      end
      return (c.n_buckets > lim) ? lim : c.n_buckets;
   endfunction

endpackage

// ===== hdl/mbd_front.sv =====
// Front part of the decimator: accepts samples, classifies them against the
// window bounds and works out their bucket with one registered multiply.
// Depends on mbd_pkg.

module mbd_front import mbd_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_tvalid,
   output logic              req_tready,
   input  sample_type        req_sample,
   input  csr_type           csr,
   input  logic [QCNT_W-1:0] q_count,
   output logic              q_push,
   output cls_item_type      q_item
);

   typedef struct packed {
      sample_type       smp;
      kind_type         kind;
      logic             closes;
      logic             post_put;
      logic             neg;
      logic [VAL_W-1:0] x_offset;
   } s1_type;

   typedef struct packed {
      sample_type       smp;
      kind_type         kind;
      logic             closes;
      logic             post_put;
      logic             neg;
      logic [VAL_W-1:0] prod_hi;
   } s2_type;

   logic             s1_valid_ff, s1_valid_in;
   logic             s2_valid_ff, s2_valid_in;
   s1_type           s1_ff, s1_in;
   s2_type           s2_ff, s2_in;

   logic             req_accept;
   logic [CNT_W-1:0] eff, beg, win_end, win_cnt, lim, idx_w;
   logic [CNT_W:0]   end_sum;
   logic [BKT_W-1:0] nb, nb_m1;
   logic             pass_mode;
   logic [VAL_W:0]   diff;
   logic [2*VAL_W-1:0] prod;

   // Room must be left in the queue for everything still in the pipeline
   assign req_tready = (QSUM_W'(q_count) + QSUM_W'(s1_valid_ff) + QSUM_W'(s2_valid_ff))
                       < QSUM_W'(QUEUE_DEPTH);
   assign req_accept = req_tvalid && req_tready;

   // Window bounds from the configuration
   always_comb begin
      eff       = eff_count(csr);
      nb        = eff_buckets(csr);
      beg       = (csr.range_first != '0) ? csr.range_first - CNT_W'(1) : '0;
      end_sum   = {1'b0, csr.range_after} + (CNT_W+1)'(1);
      win_end   = (end_sum > {1'b0, eff}) ? eff : end_sum[CNT_W-1:0];
      win_cnt   = (win_end > beg) ? win_end - beg : '0;
      pass_mode = win_cnt <= CNT_W'({nb, 1'b0});
      lim       = (csr.range_after < eff) ? csr.range_after : eff;
      idx_w     = CNT_W'(req_sample.idx);
   end

   // Classification and distance from the origin
   always_comb begin
      s1_valid_in = req_accept;
      diff        = {req_sample.x[VAL_W-1], req_sample.x}
                    - {csr.x_origin[VAL_W-1], csr.x_origin};
      s1_in.smp      = req_sample;
      s1_in.neg      = diff[VAL_W];
      s1_in.x_offset = diff[VAL_W-1:0];
      s1_in.closes   = (idx_w + CNT_W'(1)) == lim;
      s1_in.post_put = idx_w == csr.range_after;
      s1_in.kind     = KIND_STRAY;
      if (pass_mode) begin
         if (idx_w >= beg && idx_w < win_end) begin
            s1_in.kind = KIND_PASS;
         end
      end else if (csr.range_first != '0 && idx_w == beg) begin
         s1_in.kind = KIND_PRE;
      end else if (idx_w >= csr.range_first && idx_w < lim) begin
         s1_in.kind = KIND_INRANGE;
      end else if (idx_w >= lim) begin
         s1_in.kind = KIND_POST;
      end
   end

   // Bucket product; only the integer part is kept
   always_comb begin
      prod          = (2*VAL_W)'(s1_ff.x_offset) * (2*VAL_W)'(csr.bucket_scale);
      s2_valid_in   = s1_valid_ff;
      s2_in.smp      = s1_ff.smp;
      s2_in.kind     = s1_ff.kind;
      s2_in.closes   = s1_ff.closes;
      s2_in.post_put = s1_ff.post_put;
      s2_in.neg      = s1_ff.neg;
      s2_in.prod_hi  = prod[2*VAL_W-1:VAL_W];
   end

   // Clamp the bucket and hand the item to the queue
   always_comb begin
      nb_m1           = nb - BKT_W'(1);
      q_push          = s2_valid_ff;
      q_item.smp      = s2_ff.smp;
      q_item.kind     = s2_ff.kind;
      q_item.closes   = s2_ff.closes;
      q_item.post_put = s2_ff.post_put;
      if (s2_ff.neg) begin
         q_item.bucket = '0;
      end else if (s2_ff.prod_hi > VAL_W'(nb_m1)) begin
         q_item.bucket = nb_m1;
      end else begin
         q_item.bucket = s2_ff.prod_hi[BKT_W-1:0];
      end
   end

   // Stage valid flags
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         s2_valid_ff <= s2_valid_in;
      end
   end

   // Stage payloads
   always_ff @(posedge clock) begin
      s1_ff <= s1_in;
      s2_ff <= s2_in;
   end

endmodule

// ===== hdl/mbd_queue.sv =====
// Short queue of classified samples between the front and back parts.
// Depends on mbd_pkg.

module mbd_queue import mbd_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  cls_item_type      push_item,
   input  logic              pop,
   output logic              q_valid,
   output cls_item_type      head,
   output logic [QCNT_W-1:0] count
);

   cls_item_type      entry_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0] count_ff, count_in;

   assign q_valid = count_ff != '0;
   assign head    = entry_ff[rd_ptr_ff];
   assign count   = count_ff;

   // Pointer and fill count update
   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + QPTR_W'(1) : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + QPTR_W'(1) : rd_ptr_ff;
      count_in  = count_ff + QCNT_W'(push) - QCNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Entry storage
   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_item;
      end
   end

`ifndef SYNTH
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push && !pop |-> count_ff < QCNT_W'(QUEUE_DEPTH))
      else $error("queue written while full");

   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      pop |-> count_ff != '0)
      else $error("queue read while empty");

   a_count_track: assert property (@(posedge clock) disable iff (reset)
      push && !pop |=> count_ff == $past(count_ff) + QCNT_W'(1))
      else $error("queue fill count lost a write");
`endif

endmodule

// ===== hdl/mbd_back.sv =====
// Back part of the decimator: keeps the open bucket's minimum and maximum,
// forms the results of each sample and buffers them for the result channel.
// Depends on mbd_pkg.

module mbd_back import mbd_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  csr_type      csr,
   input  logic         q_valid,
   input  cls_item_type q_item,
   output logic         q_pop,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output rsp_type      rsp_item
);

   typedef struct packed {
      logic       valid;
      sample_type smp;
   } cand_type;

   // Bucket state
   logic [BKT_W-1:0]  cur_bucket_ff, cur_bucket_in;
   logic              open_ff, open_in;
   sample_type        low_ff, low_in;
   sample_type        high_ff, high_in;
   logic [CNT_W-1:0]  last_emit_ff, last_emit_in;

   // Result buffer, head at entry 0
   rsp_type           buf_ff [RBUF_DEPTH];
   rsp_type           buf_in [RBUF_DEPTH];
   logic [RCNT_W-1:0] buf_count_ff, buf_count_in;

   logic              pop_out, take, change, dec, seen;
   logic [RCNT_W-1:0] count_after, pos;
   logic [CNT_W-1:0]  eff, le;
   cand_type          cand [NUM_CAND];
   logic [NUM_CAND-1:0] emit, ends;

   function automatic sample_type first_of(sample_type lo, sample_type hi);
      return (lo.idx <= hi.idx) ? lo : hi;
   endfunction

   function automatic sample_type second_of(sample_type lo, sample_type hi);
      return (lo.idx <= hi.idx) ? hi : lo;
   endfunction

   assign rsp_tvalid = buf_count_ff != '0;
   assign rsp_item   = buf_ff[0];

   // Take an item only when the buffer can hold its worst-case burst
   always_comb begin
      pop_out     = rsp_tvalid && rsp_tready;
      count_after = buf_count_ff - RCNT_W'(pop_out);
      take        = q_valid && (count_after <= RCNT_W'(1));
      q_pop       = take;
   end

   // Bucket tracking and candidate results
   always_comb begin
      cur_bucket_in = cur_bucket_ff;
      open_in       = open_ff;
      low_in        = low_ff;
      high_in       = high_ff;
      change        = 1'b0;
      dec           = 1'b1;
      for (int i = 0; i < NUM_CAND; i++) begin
         cand[i] = '0;
      end
      if (take) begin
         unique case (q_item.kind)
            KIND_PASS: begin
               dec     = 1'b0;
               cand[2] = '{valid: 1'b1, smp: q_item.smp};
            end
            KIND_PRE: begin
               cand[2] = '{valid: 1'b1, smp: q_item.smp};
            end
            KIND_INRANGE: begin
               change = !open_ff || (q_item.bucket != cur_bucket_ff);
               if (change) begin
                  // Flush the previous bucket and open a new one
                  cand[0]       = '{valid: open_ff, smp: first_of(low_ff, high_ff)};
                  cand[1]       = '{valid: open_ff, smp: second_of(low_ff, high_ff)};
                  open_in       = 1'b1;
                  cur_bucket_in = q_item.bucket;
                  low_in        = q_item.smp;
                  high_in       = q_item.smp;
               end else begin
                  if ($signed(q_item.smp.y) < $signed(low_ff.y)) begin
                     low_in = q_item.smp;
                  end
                  if ($signed(q_item.smp.y) > $signed(high_ff.y)) begin
                     high_in = q_item.smp;
                  end
               end
               // Last sample of the range closes the bucket
               if (q_item.closes) begin
                  cand[2] = '{valid: 1'b1, smp: first_of(low_in, high_in)};
                  cand[3] = '{valid: 1'b1, smp: second_of(low_in, high_in)};
                  open_in = 1'b0;
               end
            end
            KIND_POST: begin
               cand[0] = '{valid: open_ff, smp: first_of(low_ff, high_ff)};
               cand[1] = '{valid: open_ff, smp: second_of(low_ff, high_ff)};
               cand[2] = '{valid: q_item.post_put, smp: q_item.smp};
               open_in = 1'b0;
            end
            default: begin
            end
         endcase
      end
   end

   // Drop repeated indices and indices past the series end
   always_comb begin
      eff = eff_count(csr);
      le  = last_emit_ff;
      for (int i = 0; i < NUM_CAND; i++) begin
         emit[i] = cand[i].valid && (CNT_W'(cand[i].smp.idx) != le)
                   && (CNT_W'(cand[i].smp.idx) < eff);
         if (emit[i]) begin
            le = CNT_W'(cand[i].smp.idx);
         end
      end
      last_emit_in = le;
      seen = 1'b0;
      for (int i = NUM_CAND - 1; i >= 0; i--) begin
         ends[i] = emit[i] && !seen;
         seen    = seen || emit[i];
      end
   end

   // Shift out the delivered result and append the new ones
   always_comb begin
      for (int i = 0; i < RBUF_DEPTH - 1; i++) begin
         buf_in[i] = pop_out ? buf_ff[i+1] : buf_ff[i];
      end
      buf_in[RBUF_DEPTH-1] = buf_ff[RBUF_DEPTH-1];
      pos = count_after;
      for (int i = 0; i < NUM_CAND; i++) begin
         if (emit[i]) begin
            buf_in[pos[RPTR_W-1:0]] = '{smp: cand[i].smp, decimating: dec,
                                        run_end: ends[i]};
            pos = pos + RCNT_W'(1);
         end
      end
      buf_count_in = pos;
   end

   // Control and bucket state
   always_ff @(posedge clock) begin
      if (reset) begin
         cur_bucket_ff <= RST_BUCKET_COUNT;
         open_ff       <= 1'b0;
         low_ff        <= '0;
         high_ff       <= '0;
         last_emit_ff  <= '1;
         buf_count_ff  <= '0;
      end else begin
         cur_bucket_ff <= cur_bucket_in;
         open_ff       <= open_in;
         low_ff        <= low_in;
         high_ff       <= high_in;
         last_emit_ff  <= last_emit_in;
         buf_count_ff  <= buf_count_in;
      end
   end

   // Result buffer payload
   always_ff @(posedge clock) begin
      for (int i = 0; i < RBUF_DEPTH; i++) begin
         buf_ff[i] <= buf_in[i];
      end
   end

`ifndef SYNTH
   a_buf_bound: assert property (@(posedge clock) disable iff (reset)
      buf_count_ff <= RCNT_W'(RBUF_DEPTH))
      else $error("result buffer overfilled");

   a_burst_limit: assert property (@(posedge clock) disable iff (reset)
      take |-> $countones(emit) <= 3)
      else $error("more than three results from one sample");

   a_bucket_range: assert property (@(posedge clock) disable iff (reset)
      open_ff |-> cur_bucket_ff < BKT_W'(MAX_BUCKETS))
      else $error("open bucket outside the bucket range");

   a_one_run_end: assert property (@(posedge clock) disable iff (reset)
      take && (emit != '0) |-> $onehot(ends))
      else $error("result burst without a single run end");
`endif

endmodule

// ===== hdl/minmax_bucket_decimator_unit.sv =====
// Top level of the min/max bucket decimator: configuration registers, stream
// packing and the front, queue and back parts. Depends on mbd_pkg and all mbd_ modules.

// The block takes one sample per clock cycle while req_tready is high and gives its
// results one per cycle while rsp_tready is high, after classification, the bucket
// multiply, the queue and the result buffer. A sample that closes a bucket gives up
// to three results, and the result buffer in the back part drains them at one per
// cycle, so the input pauses after such a sample while the output port is the limit;
// with the usual average of at most one result per sample the input runs at one
// sample per cycle. Registers are to be written by the user only while the block is
// idle, which the block does not enforce; no clearing pass is needed after reset.

module minmax_bucket_decimator_unit import mbd_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   // Sample requests
   input  logic                 req_tvalid,
   output logic                 req_tready,
   input  logic [TDATA_W-1:0]   req_tdata,  // sample_index, x_value, y_value
   // Results
   output logic                 rsp_tvalid,
   input  logic                 rsp_tready,
   output logic [TDATA_W-1:0]   rsp_tdata,  // kept_index, kept_x, kept_y
   output logic                 rsp_tuser,  // decimating
   output logic                 rsp_tlast,  // run_end
   // Configuration writes
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [VAL_W-1:0]     csr_wdata
);

   csr_type           csr_ff, csr_in;
   sample_type        req_sample;
   logic              q_push, q_pop, q_valid;
   cls_item_type      q_item, q_head;
   logic [QCNT_W-1:0] q_count;
   rsp_type           rsp_item;

   assign csr_ready = 1'b1;

   // Register writes
   always_comb begin
      csr_in = csr_ff;
      if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_X_ORIGIN:     csr_in.x_origin     = csr_wdata;
            CSR_BUCKET_SCALE: csr_in.bucket_scale = csr_wdata;
            CSR_BUCKET_COUNT: csr_in.n_buckets    = csr_wdata[BKT_W-1:0];
            CSR_FIRST_INSIDE: csr_in.range_first  = csr_wdata[CNT_W-1:0];
            CSR_AFTER_INSIDE: csr_in.range_after  = csr_wdata[CNT_W-1:0];
            CSR_SAMPLE_COUNT: csr_in.sample_count = csr_wdata[CNT_W-1:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         csr_ff.x_origin     <= '0;
         csr_ff.bucket_scale <= RST_BUCKET_SCALE;
         csr_ff.n_buckets    <= RST_BUCKET_COUNT;
         csr_ff.range_first  <= '0;
         csr_ff.range_after  <= '0;
         csr_ff.sample_count <= '0;
      end else begin
         csr_ff <= csr_in;
      end
   end

   // Stream unpacking and packing
   assign req_sample.idx = req_tdata[IDX_W-1:0];
   assign req_sample.x   = req_tdata[IDX_W+VAL_W-1:IDX_W];
   assign req_sample.y   = req_tdata[IDX_W+2*VAL_W-1:IDX_W+VAL_W];

   assign rsp_tdata = TDATA_W'({rsp_item.smp.y, rsp_item.smp.x, rsp_item.smp.idx});
   assign rsp_tuser = rsp_item.decimating;
   assign rsp_tlast = rsp_item.run_end;

   mbd_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_sample (req_sample),
      .csr        (csr_ff),
      .q_count    (q_count),
      .q_push     (q_push),
      .q_item     (q_item)
   );

   mbd_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_item (q_item),
      .pop       (q_pop),
      .q_valid   (q_valid),
      .head      (q_head),
      .count     (q_count)
   );

   mbd_back u_back (
      .clock      (clock),
      .reset      (reset),
      .csr        (csr_ff),
      .q_valid    (q_valid),
      .q_item     (q_head),
      .q_pop      (q_pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_item   (rsp_item)
   );

endmodule
